// File: rtl/fsm_pkg.sv
// Shared types, codes and defaults for the first substring match unit.
`timescale 1ns / 1ps

package fsm_pkg;

    // Field widths, fixed by the interface
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 12;
    localparam int ERR_W    = 2;

    // Parameter defaults
    localparam int MAX_PATTERN_DEF = 16;
    localparam int MAX_TEXT_DEF    = 4096;

    // Depth of the queues either side of the search core
    localparam int QUEUE_DEPTH = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PAT_BYTE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PAT_END   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TEXT_BYTE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_TEXT_END  = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_PAT_LONG  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TEXT_LONG = 2'd2;

    // Classified input transaction, one flag per action
    typedef struct packed {
        logic              is_pat;
        logic              is_pat_end;
        logic              is_text;
        logic              is_text_end;
        logic [CHAR_W-1:0] ch;
    } t_item;

    // Result transaction
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [ERR_W-1:0]   err;
    } t_result;

    localparam int ITEM_W   = $bits(t_item);
    localparam int RESULT_W = $bits(t_result);

endpackage

// File: rtl/fsm_fifo.sv
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps

module fsm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/fsm_front.sv
// Front end: decodes the action of each input transaction and queues it.
`timescale 1ns / 1ps

module fsm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [fsm_pkg::ACTION_W-1:0] i_action,
    input  logic [fsm_pkg::CHAR_W-1:0]   i_char_value,
    output logic                         o_valid,
    input  logic                         i_take,
    output fsm_pkg::t_item               o_item
);
    import fsm_pkg::*;

    t_item                w_item;
    logic [ITEM_W-1:0]    w_q_data;
    logic                 w_empty;

    // classify the action into one flag each
    always_comb begin
        w_item             = '0;
        w_item.ch          = i_char_value;
        case (i_action)
            ACT_PAT_BYTE:  w_item.is_pat      = 1'b1;
            ACT_PAT_END:   w_item.is_pat_end  = 1'b1;
            ACT_TEXT_BYTE: w_item.is_text     = 1'b1;
            default:       w_item.is_text_end = 1'b1;
        endcase
    end

    fsm_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_item),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_empty (w_empty),
        .o_data  (w_q_data)
    );

    assign o_valid = !w_empty;
    assign o_item  = t_item'(w_q_data);

endmodule

// File: rtl/fsm_core.sv
// Search core: pattern shift store, text window compare and result build.
`timescale 1ns / 1ps

module fsm_core #(
    parameter int MAX_PATTERN = fsm_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = fsm_pkg::MAX_TEXT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fsm_pkg::t_item     i_item,
    output logic               o_take,
    output logic               o_res_push,
    output fsm_pkg::t_result   o_res,
    input  logic               i_res_full
);
    import fsm_pkg::*;

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W  = $clog2(MAX_TEXT + 1);
    localparam int MAX_LC = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int CMP_W  = (MAX_LC > INDEX_W) ? MAX_LC : INDEX_W;

    // Pattern held newest byte first, so that entry k lines up with window entry k
    logic [CHAR_W-1:0]  r_pat [MAX_PATTERN];
    logic [CHAR_W-1:0]  r_win [MAX_PATTERN];
    logic [CHAR_W-1:0]  w_win_nx [MAX_PATTERN];
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_match, n_match;
    logic [INDEX_W-1:0] r_idx, n_idx;
    logic [ERR_W-1:0]   r_err, n_err;

    logic [MAX_PATTERN-1:0] w_mask;
    logic [MAX_PATTERN-1:0] w_eq;
    logic [CMP_W-1:0]       w_cnt_ext;
    logic [CMP_W-1:0]       w_len_ext;
    logic [CMP_W-1:0]       w_start;
    logic                   w_pat_room;
    logic                   w_text_room;
    logic                   w_hit;
    logic                   w_found;

    // a text end needs room in the result queue; all else goes straight in
    assign o_take      = i_valid && (!i_item.is_text_end || !i_res_full);
    assign w_pat_room  = (r_len < LEN_W'(MAX_PATTERN));
    assign w_text_room = (r_cnt < CNT_W'(MAX_TEXT));

    // window after this byte, and its compare with the live part of the pattern
    assign w_win_nx[0] = i_item.ch;
    generate
        for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cmp
            if (k > 0) begin : g_shift
                assign w_win_nx[k] = r_win[k-1];
            end
            assign w_mask[k] = (r_len > LEN_W'(k));
            assign w_eq[k]   = (w_win_nx[k] == r_pat[k]);
        end
    endgenerate

    assign w_cnt_ext = CMP_W'(r_cnt) + 1'b1;
    assign w_len_ext = CMP_W'(r_len);
    assign w_start   = w_cnt_ext - w_len_ext;
    assign w_hit     = (r_len != '0) && (w_cnt_ext >= w_len_ext) && (&(w_eq | ~w_mask));

    // result of a text end
    assign w_found          = (r_err == ERR_NONE) && ((r_len == '0) || r_match);
    assign o_res_push       = o_take && i_item.is_text_end;
    assign o_res.found      = w_found;
    assign o_res.index      = (w_found && (r_len != '0)) ? r_idx : '0;
    assign o_res.err        = r_err;

    // control state update
    always_comb begin
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_match = r_match;
        n_idx   = r_idx;
        n_err   = r_err;
        if (o_take) begin
            if (i_item.is_pat) begin
                if (w_pat_room) begin
                    n_len = r_len + 1'b1;
                end else if (r_err == ERR_NONE) begin
                    n_err = ERR_PAT_LONG;
                end
            end else if (i_item.is_pat_end) begin
                n_cnt   = '0;
                n_match = 1'b0;
                n_idx   = '0;
            end else if (i_item.is_text) begin
                if (w_text_room) begin
                    n_cnt = r_cnt + 1'b1;
                    if (!r_match && w_hit) begin
                        n_match = 1'b1;
                        n_idx   = w_start[INDEX_W-1:0];
                    end
                end else if (r_err == ERR_NONE) begin
                    n_err = ERR_TEXT_LONG;
                end
            end else begin
                // text end: back to the reset state
                n_len   = '0;
                n_cnt   = '0;
                n_match = 1'b0;
                n_idx   = '0;
                n_err   = ERR_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_cnt   <= '0;
            r_match <= 1'b0;
            r_idx   <= '0;
            r_err   <= ERR_NONE;
        end else begin
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_match <= n_match;
            r_idx   <= n_idx;
            r_err   <= n_err;
        end
    end

    // pattern and window shift lines; entries are only read once written
    always_ff @(posedge i_clk) begin
        if (o_take && i_item.is_pat && w_pat_room) begin
            r_pat[0] <= i_item.ch;
            for (int k = 1; k < MAX_PATTERN; k++) begin
                r_pat[k] <= r_pat[k-1];
            end
        end
        if (o_take && i_item.is_text && w_text_room) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_win[k] <= w_win_nx[k];
            end
        end
    end

endmodule

// File: rtl/first_substring_match_unit.sv
// Top level of the first substring match unit.
//
// Finds the first occurrence of a pattern in a text by a window compare.
// Input channel (push/full): each transaction carries an action and a byte:
// pattern byte, end of pattern, text byte or end of text. Pattern bytes are
// stored (up to MAX_PATTERN), end of pattern clears the text side, text
// bytes (up to MAX_TEXT) shift through a window that is compared in
// parallel with the stored pattern on every byte.
// Result channel (empty/pop): one transaction per end of text with found,
// match_index and error_code; the unit then returns to its reset state.
// Throughput: one input transaction per cycle while no end of text waits for
// result queue room; the window compare in the search core is combinational.
// The result of an end of text reaches the outputs through the input queue, then the result queue.
// When the receiver stalls, results wait in a two-entry result queue; text
// and pattern transactions keep flowing until an end of text meets a full result
// queue; it waits with all behind it, and full rises once the input queue fills.
// Reset (synchronous, active low) empties both queues and clears the
// pattern length, text count, match and error state.
`timescale 1ns / 1ps

module first_substring_match_unit #(
    parameter int MAX_PATTERN = fsm_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = fsm_pkg::MAX_TEXT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [fsm_pkg::ACTION_W-1:0] i_action,
    input  logic [fsm_pkg::CHAR_W-1:0]   i_char_value,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_found,
    output logic [fsm_pkg::INDEX_W-1:0]  o_match_index,
    output logic [fsm_pkg::ERR_W-1:0]    o_error_code
);
    import fsm_pkg::*;

    t_item               w_item;
    logic                w_valid;
    logic                w_take;
    logic                w_res_push;
    logic                w_res_full;
    t_result             w_res;
    logic [RESULT_W-1:0] w_res_q;
    t_result             w_res_out;

    fsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_char_value (i_char_value),
        .o_valid      (w_valid),
        .i_take       (w_take),
        .o_item       (w_item)
    );

    fsm_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .o_take     (w_take),
        .o_res_push (w_res_push),
        .o_res      (w_res),
        .i_res_full (w_res_full)
    );

    // result queue towards the receiver
    fsm_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_q)
    );

    assign w_res_out     = t_result'(w_res_q);
    assign o_found       = w_res_out.found;
    assign o_match_index = w_res_out.index;
    assign o_error_code  = w_res_out.err;

endmodule
